>>> rtl/kf2_pkg.sv
// ----------------------------------------------------------------------------
// kf2_pkg
// types and codes shared by the two-state kalman filter
// ----------------------------------------------------------------------------
`default_nettype none
package kf2_pkg;

   typedef enum logic [2:0] {
      CSR_TIME_STEP    = 3'd0,
      CSR_MOTION_POS   = 3'd1,
      CSR_MOTION_VEL   = 3'd2,
      CSR_MEAS_VAR     = 3'd3,
      CSR_PROC_VAR_POS = 3'd4,
      CSR_PROC_VAR_VEL = 3'd5,
      CSR_INIT_VAR     = 3'd6
   } csr_index_type;

   localparam logic [1:0] FAULT_OK   = 2'd0;
   localparam logic [1:0] FAULT_SAT  = 2'd1;
   localparam logic [1:0] FAULT_SKIP = 2'd2;

   // datapath operand selectors
   typedef enum logic [3:0] {
      OP_Y, OP_S, OP_K0, OP_K1, OP_X0U, OP_X1U, OP_P00U, OP_P01U, OP_P11U,
      OP_X0P, OP_X1P, OP_A, OP_B, OP_P00P, OP_P11P
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_Y, ST_S, ST_K0_GO, ST_K0_WAIT, ST_K1_GO, ST_K1_WAIT,
      ST_X0U, ST_X1U, ST_P00U, ST_P01U, ST_P11U,
      ST_X0P, ST_X1P, ST_A, ST_B, ST_P00P, ST_P11P, ST_OUT
   } state_type;

   typedef struct packed {
      logic  load;      // capture measurement, clear skip, restart sat flag
      logic  step;      // run one operation
      op_type op;
      logic  div_start;
      logic  div_sel;   // 0 k0, 1 k1
      logic  publish;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic div_busy;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/kf2_div.sv
// ----------------------------------------------------------------------------
// kf2_div
// restoring divider, one quotient bit a cycle, saturating signed result
// ----------------------------------------------------------------------------
`default_nettype none
module kf2_div #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [WORD_WIDTH-1:0] num,
   input  wire logic signed [WORD_WIDTH-1:0] den,
   output logic                              busy,
   output logic signed [WORD_WIDTH-1:0]      quot,
   output logic                              sat
);
   localparam int NW = WORD_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]         num_ff, num_in;
   logic [NW-1:0]         q_ff, q_in;
   logic [WORD_WIDTH:0]   rem_ff, rem_in;
   logic [WORD_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH-1:0] mag;
   logic [NW-1:0]         lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[WORD_WIDTH-1:0], num_ff[NW-1]};
      mag     = num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : WORD_WIDTH'(num);
      if (start) begin
         num_in  = {mag, {FRAC_BITS{1'b0}}};
         den_in  = WORD_WIDTH'(den);
         neg_in  = num[WORD_WIDTH-1];
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_comb begin
      lim = NW'({1'b0, {(WORD_WIDTH-1){1'b1}}}) + NW'(neg_ff);
      sat = q_ff > lim;
      if (sat)
         quot = neg_ff ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}};
      else
         quot = neg_ff ? WORD_WIDTH'(-q_ff) : WORD_WIDTH'(q_ff);
   end

   assign busy = busy_ff;
endmodule
`default_nettype wire

>>> rtl/kf2_datapath.sv
// ----------------------------------------------------------------------------
// kf2_datapath
// state registers, one shared multiplier and adder, follow-up adder, divider and result word
// ----------------------------------------------------------------------------
`default_nettype none
module kf2_datapath #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire kf2_pkg::cmd_type             cmd,
   output kf2_pkg::status_type               status,
   input  wire logic signed [31:0]           measured_pos,
   input  wire logic [30:0]                  time_step,
   input  wire logic signed [31:0]           motion_pos,
   input  wire logic signed [31:0]           motion_vel,
   input  wire logic [30:0]                  meas_var,
   input  wire logic [30:0]                  proc_var_pos,
   input  wire logic [30:0]                  proc_var_vel,
   input  wire logic [30:0]                  init_var_rst,
   output logic signed [WORD_WIDTH-1:0]      est_pos,
   output logic signed [WORD_WIDTH-1:0]      est_vel,
   output logic [WORD_WIDTH-2:0]             var_pos,
   output logic signed [WORD_WIDTH-1:0]      cov_pos_vel,
   output logic [WORD_WIDTH-2:0]             var_vel,
   output logic [1:0]                        fault
);
   localparam int W  = WORD_WIDTH;
   localparam int PW = 2 * W;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0] x0_ff, x0_in, x1_ff, x1_in;
   logic signed [W-1:0] p00_ff, p00_in, p01_ff, p01_in, p11_ff, p11_in;
   logic signed [W-1:0] z_ff, z_in, y_ff, y_in, s_ff, s_in;
   logic signed [W-1:0] k0_ff, k0_in, k1_ff, k1_in, a_ff, a_in, b_ff, b_in;
   logic                skip_ff, skip_in, sat_ff, sat_in;
   logic signed [W-1:0] ox0_ff, ox1_ff, op01_ff;
   logic [W-2:0]        op00_ff, op11_ff;
   logic [1:0]          fault_ff;

   logic signed [W-1:0] ma, mb, ad, prod, sum, res, dq;
   logic                sub, use_mul, sum_sat, mul_sat, dsat, div_busy;
   logic signed [PW-1:0] full;
   logic signed [PW-1:0] shifted;
   logic signed [W:0]   wide;

   // second-stage adds (motion into x0, q_pos into p00) run as a follow-up
   logic                fin_x0_ff, fin_x0_in, fin_p00_ff, fin_p00_in;
   logic signed [W-1:0] fw, fadd, fres;
   logic                fsat;

   function automatic logic signed [W-1:0] sat_in32(input logic signed [31:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      if (e > 64'(WMAX)) sat_in32 = WMAX;
      else if (e < 64'(WMIN)) sat_in32 = WMIN;
      else sat_in32 = W'(e);
   endfunction

   function automatic logic sat_ov32(input logic signed [31:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      sat_ov32 = (e > 64'(WMAX)) || (e < 64'(WMIN));
   endfunction

   function automatic logic signed [W-1:0] sat_u31(input logic [30:0] v);
      if ({33'd0, v} > 64'(WMAX)) sat_u31 = WMAX;
      else sat_u31 = W'({33'd0, v});
   endfunction

   function automatic logic ov_u31(input logic [30:0] v);
      ov_u31 = {33'd0, v} > 64'(WMAX);
   endfunction

   kf2_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (cmd.div_sel ? p01_ff : p00_ff),
      .den   (s_ff),
      .busy  (div_busy),
      .quot  (dq),
      .sat   (dsat)
   );

   // operand selection
   always_comb begin
      ma = '0; mb = '0; ad = '0; sub = 1'b0; use_mul = 1'b0;
      unique case (cmd.op)
         kf2_pkg::OP_Y:    begin ad = z_ff; mb = x0_ff; sub = 1'b1; end
         kf2_pkg::OP_S:    begin ad = p00_ff; mb = sat_u31(meas_var); end
         kf2_pkg::OP_K0, kf2_pkg::OP_K1: begin ad = '0; mb = '0; end
         kf2_pkg::OP_X0U:  begin ad = x0_ff; ma = k0_ff; mb = y_ff; use_mul = 1'b1; end
         kf2_pkg::OP_X1U:  begin ad = x1_ff; ma = k1_ff; mb = y_ff; use_mul = 1'b1; end
         kf2_pkg::OP_P00U: begin ad = p00_ff; ma = k0_ff; mb = p00_ff; use_mul = 1'b1;
                                 sub = 1'b1; end
         kf2_pkg::OP_P01U: begin ad = p01_ff; ma = k0_ff; mb = p01_ff; use_mul = 1'b1;
                                 sub = 1'b1; end
         kf2_pkg::OP_P11U: begin ad = p11_ff; ma = k1_ff; mb = p01_ff; use_mul = 1'b1;
                                 sub = 1'b1; end
         kf2_pkg::OP_X0P:  begin ad = x0_ff; ma = sat_u31(time_step); mb = x1_ff;
                                 use_mul = 1'b1; end
         kf2_pkg::OP_X1P:  begin ad = x1_ff; mb = sat_in32(motion_vel); end
         kf2_pkg::OP_A:    begin ad = p00_ff; ma = sat_u31(time_step); mb = p01_ff;
                                 use_mul = 1'b1; end
         kf2_pkg::OP_B:    begin ad = p01_ff; ma = sat_u31(time_step); mb = p11_ff;
                                 use_mul = 1'b1; end
         kf2_pkg::OP_P00P: begin ad = a_ff; ma = sat_u31(time_step); mb = b_ff;
                                 use_mul = 1'b1; end
         kf2_pkg::OP_P11P: begin ad = p11_ff; mb = sat_u31(proc_var_vel); end
         default:          begin ad = '0; end
      endcase
   end

   // multiply with truncation toward zero and saturation
   always_comb begin
      full    = PW'(ma) * PW'(mb);
      if (full < 0) shifted = -((-full) >>> FRAC_BITS);
      else shifted = full >>> FRAC_BITS;
      mul_sat = (shifted > PW'(WMAX)) || (shifted < PW'(WMIN));
      if (shifted > PW'(WMAX)) prod = WMAX;
      else if (shifted < PW'(WMIN)) prod = WMIN;
      else prod = W'(shifted);
   end

   // saturating add or subtract
   always_comb begin
      logic signed [W-1:0] rhs;
      rhs = use_mul ? prod : mb;
      wide = sub ? ((W+1)'(ad) - (W+1)'(rhs)) : ((W+1)'(ad) + (W+1)'(rhs));
      sum_sat = (wide > (W+1)'(WMAX)) || (wide < (W+1)'(WMIN));
      if (wide > (W+1)'(WMAX)) sum = WMAX;
      else if (wide < (W+1)'(WMIN)) sum = WMIN;
      else sum = W'(wide);
      res = sum;
   end

   always_comb begin
      x0_in = x0_ff; x1_in = x1_ff; p00_in = p00_ff; p01_in = p01_ff; p11_in = p11_ff;
      z_in = z_ff; y_in = y_ff; s_in = s_ff; k0_in = k0_ff; k1_in = k1_ff;
      a_in = a_ff; b_in = b_ff; skip_in = skip_ff; sat_in = sat_ff;
      if (cmd.load) begin
         z_in    = sat_in32(measured_pos);
         sat_in  = sat_ov32(measured_pos) || ov_u31(time_step) || ov_u31(meas_var);
         skip_in = 1'b0;
      end else if (cmd.step) begin
         if (cmd.op == kf2_pkg::OP_K0) begin
            k0_in = dq; sat_in = sat_ff | dsat;
         end else if (cmd.op == kf2_pkg::OP_K1) begin
            k1_in = dq; sat_in = sat_ff | dsat;
         end else begin
            sat_in = sat_ff | sum_sat | (use_mul & mul_sat);
         end
         unique case (cmd.op)
            kf2_pkg::OP_Y:    y_in = res;
            kf2_pkg::OP_S:    begin s_in = res; skip_in = (res <= 0); end
            kf2_pkg::OP_X0U:  x0_in = res;
            kf2_pkg::OP_X1U:  x1_in = res;
            kf2_pkg::OP_P00U: p00_in = res;
            kf2_pkg::OP_P01U: b_in = res;   // held until p11 update uses old p01
            kf2_pkg::OP_P11U: begin p11_in = res; p01_in = b_ff; end
            kf2_pkg::OP_X0P:  x0_in = res;
            kf2_pkg::OP_X1P:  x1_in = res;
            kf2_pkg::OP_A:    a_in = res;
            kf2_pkg::OP_B:    b_in = res;
            kf2_pkg::OP_P00P: begin a_in = res; p01_in = b_ff; end
            kf2_pkg::OP_P11P: p11_in = res;
            default:          ;
         endcase
      end
      if (fin_x0_ff) x0_in = fres;
      if (fin_p00_ff) p00_in = fres;
   end

   always_comb begin
      fin_x0_in  = cmd.step && cmd.op == kf2_pkg::OP_X0P;
      fin_p00_in = cmd.step && cmd.op == kf2_pkg::OP_P00P;
   end
   always_comb begin
      logic signed [W:0] t;
      fw   = fin_x0_ff ? x0_ff : a_ff;
      fadd = fin_x0_ff ? sat_in32(motion_pos) : sat_u31(proc_var_pos);
      t    = (W+1)'(fw) + (W+1)'(fadd);
      fsat = (t > (W+1)'(WMAX)) || (t < (W+1)'(WMIN))
             || (fin_x0_ff ? sat_ov32(motion_pos) : ov_u31(proc_var_pos));
      if (t > (W+1)'(WMAX)) fres = WMAX;
      else if (t < (W+1)'(WMIN)) fres = WMIN;
      else fres = W'(t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff      <= '0;
         x1_ff      <= '0;
         p00_ff     <= sat_u31(init_var_rst);
         p01_ff     <= '0;
         p11_ff     <= sat_u31(init_var_rst);
         skip_ff    <= 1'b0;
         sat_ff     <= 1'b0;
         fin_x0_ff  <= 1'b0;
         fin_p00_ff <= 1'b0;
      end else begin
         x0_ff      <= x0_in;
         p00_ff     <= p00_in;
         x1_ff      <= x1_in;
         p01_ff     <= p01_in;
         p11_ff     <= p11_in;
         skip_ff    <= skip_in;
         sat_ff     <= sat_in | ((fin_x0_ff | fin_p00_ff) & fsat);
         fin_x0_ff  <= fin_x0_in;
         fin_p00_ff <= fin_p00_in;
      end
      z_ff  <= z_in;
      y_ff  <= y_in;
      s_ff  <= s_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
      if (cmd.publish) begin
         ox0_ff   <= x0_ff;
         ox1_ff   <= x1_ff;
         op01_ff  <= p01_ff;
         op00_ff  <= p00_ff[W-1] ? '0 : p00_ff[W-2:0];
         op11_ff  <= p11_ff[W-1] ? '0 : p11_ff[W-2:0];
         fault_ff <= skip_ff ? kf2_pkg::FAULT_SKIP
                   : (sat_ff ? kf2_pkg::FAULT_SAT : kf2_pkg::FAULT_OK);
      end
   end

   assign status      = kf2_pkg::status_type'({skip_ff, div_busy});
   assign est_pos     = ox0_ff;
   assign est_vel     = ox1_ff;
   assign var_pos     = op00_ff;
   assign cov_pos_vel = op01_ff;
   assign var_vel     = op11_ff;
   assign fault       = fault_ff;
endmodule
`default_nettype wire

>>> rtl/kf2_ctrl.sv
// ----------------------------------------------------------------------------
// kf2_ctrl
// sequencer for the update and prediction steps and the result handshake
// ----------------------------------------------------------------------------
`default_nettype none
module kf2_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output kf2_pkg::cmd_type           cmd,
   input  wire kf2_pkg::status_type   status
);
   kf2_pkg::state_type state_ff, state_in;
   logic               full_ff, full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kf2_pkg::ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kf2_pkg::ST_IDLE:    if (req_valid) state_in = kf2_pkg::ST_Y;
         kf2_pkg::ST_Y:       state_in = kf2_pkg::ST_S;
         kf2_pkg::ST_S:       state_in = kf2_pkg::ST_K0_GO;
         kf2_pkg::ST_K0_GO:   state_in = status.skip ? kf2_pkg::ST_X0P : kf2_pkg::ST_K0_WAIT;
         kf2_pkg::ST_K0_WAIT: if (!status.div_busy) state_in = kf2_pkg::ST_K1_GO;
         kf2_pkg::ST_K1_GO:   state_in = kf2_pkg::ST_K1_WAIT;
         kf2_pkg::ST_K1_WAIT: if (!status.div_busy) state_in = kf2_pkg::ST_X0U;
         kf2_pkg::ST_X0U:     state_in = kf2_pkg::ST_X1U;
         kf2_pkg::ST_X1U:     state_in = kf2_pkg::ST_P00U;
         kf2_pkg::ST_P00U:    state_in = kf2_pkg::ST_P01U;
         kf2_pkg::ST_P01U:    state_in = kf2_pkg::ST_P11U;
         kf2_pkg::ST_P11U:    state_in = kf2_pkg::ST_X0P;
         kf2_pkg::ST_X0P:     state_in = kf2_pkg::ST_X1P;
         kf2_pkg::ST_X1P:     state_in = kf2_pkg::ST_A;
         kf2_pkg::ST_A:       state_in = kf2_pkg::ST_B;
         kf2_pkg::ST_B:       state_in = kf2_pkg::ST_P00P;
         kf2_pkg::ST_P00P:    state_in = kf2_pkg::ST_P11P;
         kf2_pkg::ST_P11P:    state_in = kf2_pkg::ST_OUT;
         kf2_pkg::ST_OUT:     if (!full_ff || rsp_ready) state_in = kf2_pkg::ST_IDLE;
         default:             state_in = kf2_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.op        = kf2_pkg::OP_Y;
      req_ready     = 1'b0;
      full_in       = full_ff && !rsp_ready;
      unique case (state_ff)
         kf2_pkg::ST_IDLE:    begin req_ready = 1'b1; cmd.load = req_valid; end
         kf2_pkg::ST_Y:       begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_Y; end
         kf2_pkg::ST_S:       begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_S; end
         kf2_pkg::ST_K0_GO:   cmd.div_start = !status.skip;
         kf2_pkg::ST_K0_WAIT: begin
            cmd.op = kf2_pkg::OP_K0; cmd.step = !status.div_busy;
         end
         kf2_pkg::ST_K1_GO:   begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; end
         kf2_pkg::ST_K1_WAIT: begin
            cmd.op = kf2_pkg::OP_K1; cmd.step = !status.div_busy; cmd.div_sel = 1'b1;
         end
         kf2_pkg::ST_X0U:     begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_X0U; end
         kf2_pkg::ST_X1U:     begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_X1U; end
         kf2_pkg::ST_P00U:    begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_P00U; end
         kf2_pkg::ST_P01U:    begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_P01U; end
         kf2_pkg::ST_P11U:    begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_P11U; end
         kf2_pkg::ST_X0P:     begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_X0P; end
         kf2_pkg::ST_X1P:     begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_X1P; end
         kf2_pkg::ST_A:       begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_A; end
         kf2_pkg::ST_B:       begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_B; end
         kf2_pkg::ST_P00P:    begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_P00P; end
         kf2_pkg::ST_P11P:    begin cmd.step = 1'b1; cmd.op = kf2_pkg::OP_P11P; end
         kf2_pkg::ST_OUT:     if (!full_ff || rsp_ready) begin
            cmd.publish = 1'b1; full_in = 1'b1;
         end
         default:             ;
      endcase
   end

   assign rsp_valid = full_ff;
endmodule
`default_nettype wire

>>> rtl/kalman_filter_2state_1d_top.sv
// ----------------------------------------------------------------------------
// kalman_filter_2state_1d_top
// two-state position and velocity kalman filter, one measurement per word
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_measured_pos
// rsp      out        rsp_valid / rsp_ready  rsp_est_pos .. rsp_fault
// csr      in         csr_write              csr_index, csr_data
//
// the two gain divisions run on one restoring divider, one quotient bit a cycle,
// and take most of the time that a word needs.
// when S is not positive the gains and the update step are skipped.
// a finished result waits in the output register while the next word runs.
// reset is synchronous and restores the csr registers and the filter state.
// ----------------------------------------------------------------------------
`default_nettype none
module kalman_filter_2state_1d_top #(
   parameter int FRAC_BITS  = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [31:0]           req_measured_pos,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [WORD_WIDTH-1:0]      rsp_est_pos,
   output logic signed [WORD_WIDTH-1:0]      rsp_est_vel,
   output logic [WORD_WIDTH-2:0]             rsp_var_pos,
   output logic signed [WORD_WIDTH-1:0]      rsp_cov_pos_vel,
   output logic [WORD_WIDTH-2:0]             rsp_var_vel,
   output logic [1:0]                        rsp_fault,
   input  wire logic                         csr_write,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [31:0]                  csr_data
);
   localparam logic [30:0] INIT_VAR_RST = 31'd65536000;

   logic [30:0]        time_step_ff, meas_var_ff, qpos_ff, qvel_ff;
   logic signed [31:0] upos_ff, uvel_ff;
   kf2_pkg::cmd_type    cmd;
   kf2_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 31'd65536;
         upos_ff      <= '0;
         uvel_ff      <= '0;
         meas_var_ff  <= 31'd65536;
         qpos_ff      <= '0;
         qvel_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            kf2_pkg::CSR_TIME_STEP:    time_step_ff <= csr_data[30:0];
            kf2_pkg::CSR_MOTION_POS:   upos_ff      <= csr_data;
            kf2_pkg::CSR_MOTION_VEL:   uvel_ff      <= csr_data;
            kf2_pkg::CSR_MEAS_VAR:     meas_var_ff  <= csr_data[30:0];
            kf2_pkg::CSR_PROC_VAR_POS: qpos_ff      <= csr_data[30:0];
            kf2_pkg::CSR_PROC_VAR_VEL: qvel_ff      <= csr_data[30:0];
            // only read at reset, which restores the reset value anyway
            kf2_pkg::CSR_INIT_VAR:     ;
            default:                   ;
         endcase
      end
   end

   kf2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   kf2_datapath #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .measured_pos (req_measured_pos),
      .time_step    (time_step_ff),
      .motion_pos   (upos_ff),
      .motion_vel   (uvel_ff),
      .meas_var     (meas_var_ff),
      .proc_var_pos (qpos_ff),
      .proc_var_vel (qvel_ff),
      .init_var_rst (INIT_VAR_RST),
      .est_pos      (rsp_est_pos),
      .est_vel      (rsp_est_vel),
      .var_pos      (rsp_var_pos),
      .cov_pos_vel  (rsp_cov_pos_vel),
      .var_vel      (rsp_var_vel),
      .fault        (rsp_fault)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_ready) else $error("word accepted during division");
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fault != 2'd3) else $error("undefined fault code");
   a_rsp_after_publish: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid) else $error("published word not offered");
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives measurement words into the two-state kalman filter, predicts every
// estimate and covariance word with a fixed-point model kept here, and
// compares each response word field by field, with random stalls in most tests
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] est_pos;
      logic signed [31:0] est_vel;
      logic [30:0]        var_pos;
      logic signed [31:0] cov_pos_vel;
      logic [30:0]        var_vel;
      logic [1:0]         fault;
   } estimate_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_measured_pos = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_est_pos, rsp_est_vel, rsp_cov_pos_vel;
   logic [30:0]        rsp_var_pos, rsp_var_vel;
   logic [1:0]         rsp_fault;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   estimate_type expected_estimates[$];
   int  error_count = 0;
   bit  steady_run = 1'b0;
   int  ready_hold = 0;

   // filter copy
   longint pos_est = 0, vel_est = 0, pp = 65536000, pv = 0, vv = 65536000;
   longint dt_reg = 65536, u_pos = 0, u_vel = 0, r_reg = 65536;
   longint q_pos = 0, q_vel = 0;
   bit     sat_flag;

   always #5 clock = ~clock;

   kalman_filter_2state_1d_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_measured_pos(req_measured_pos),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_est_pos(rsp_est_pos), .rsp_est_vel(rsp_est_vel),
      .rsp_var_pos(rsp_var_pos), .rsp_cov_pos_vel(rsp_cov_pos_vel),
      .rsp_var_vel(rsp_var_vel), .rsp_fault(rsp_fault),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX) begin
         sat_flag = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         sat_flag = 1'b1;
         return WORD_MIN;
      end
      return v;
   endfunction

   function automatic longint q_mul(longint a, longint b);
      longint ma, mb, p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (ma * mb) >>> 16;
      return clamp_word(((a < 0) != (b < 0)) ? -p : p);
   endfunction

   function automatic longint q_div(longint n, longint d);
      longint q;
      q = ((n < 0 ? -n : n) <<< 16) / d;
      return clamp_word(n < 0 ? -q : q);
   endfunction

   function automatic logic [30:0] variance_out(longint v);
      return v < 0 ? 31'd0 : v[30:0];
   endfunction

   function automatic estimate_type filter_step(logic signed [31:0] z);
      estimate_type e;
      longint y, s, k0, k1, n00, n01, n11, a, b;
      bit     skip;
      sat_flag = 1'b0;
      y = clamp_word(longint'(z) - pos_est);
      s = clamp_word(pp + r_reg);
      skip = s <= 0;
      if (!skip) begin
         k0 = q_div(pp, s);
         k1 = q_div(pv, s);
         pos_est = clamp_word(pos_est + q_mul(k0, y));
         vel_est = clamp_word(vel_est + q_mul(k1, y));
         n00 = clamp_word(pp - q_mul(k0, pp));
         n01 = clamp_word(pv - q_mul(k0, pv));
         n11 = clamp_word(vv - q_mul(k1, pv));
         pp = n00; pv = n01; vv = n11;
      end
      pos_est = clamp_word(clamp_word(pos_est + q_mul(dt_reg, vel_est)) + u_pos);
      vel_est = clamp_word(vel_est + u_vel);
      a = clamp_word(pp + q_mul(dt_reg, pv));
      b = clamp_word(pv + q_mul(dt_reg, vv));
      pp = clamp_word(clamp_word(a + q_mul(dt_reg, b)) + q_pos);
      pv = b;
      vv = clamp_word(vv + q_vel);
      e.est_pos = pos_est[31:0];
      e.est_vel = vel_est[31:0];
      e.var_pos = variance_out(pp);
      e.cov_pos_vel = pv[31:0];
      e.var_vel = variance_out(vv);
      e.fault = skip ? kf2_pkg::FAULT_SKIP
              : (sat_flag ? kf2_pkg::FAULT_SAT : kf2_pkg::FAULT_OK);
      return e;
   endfunction

   // response side: random stalls and comparison
   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_estimates.size() == 0) begin
               $error("unexpected response word");
               error_count++;
            end else begin
               e = expected_estimates.pop_front();
               if (rsp_est_pos !== e.est_pos) begin
                  $error("est_pos exp %0d got %0d", e.est_pos, rsp_est_pos);
                  error_count++;
               end
               if (rsp_est_vel !== e.est_vel) begin
                  $error("est_vel exp %0d got %0d", e.est_vel, rsp_est_vel);
                  error_count++;
               end
               if (rsp_var_pos !== e.var_pos) begin
                  $error("var_pos exp %0d got %0d", e.var_pos, rsp_var_pos);
                  error_count++;
               end
               if (rsp_cov_pos_vel !== e.cov_pos_vel) begin
                  $error("cov_pos_vel exp %0d got %0d", e.cov_pos_vel, rsp_cov_pos_vel);
                  error_count++;
               end
               if (rsp_var_vel !== e.var_vel) begin
                  $error("var_vel exp %0d got %0d", e.var_vel, rsp_var_vel);
                  error_count++;
               end
               if (rsp_fault !== e.fault) begin
                  $error("fault exp %0d got %0d", e.fault, rsp_fault);
                  error_count++;
               end
            end
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else if (!steady_run && $urandom_range(0, 4) == 0) begin
            ready_hold = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(logic signed [31:0] z);
      req_valid <= 1'b1;
      req_measured_pos <= z;
      do @(posedge clock); while (!req_ready);
      expected_estimates.push_back(filter_step(z));
      if (!steady_run && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_put(kf2_pkg::csr_index_type idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   // writes every register; init_var only matters at reset
   task automatic apply_settings(logic [30:0] dt, logic [31:0] up, logic [31:0] uv,
                                 logic [30:0] r, logic [30:0] qp, logic [30:0] qv);
      wait_idle();
      csr_put(kf2_pkg::CSR_TIME_STEP, {1'b0, dt});
      csr_put(kf2_pkg::CSR_MOTION_POS, up);
      csr_put(kf2_pkg::CSR_MOTION_VEL, uv);
      csr_put(kf2_pkg::CSR_MEAS_VAR, {1'b0, r});
      csr_put(kf2_pkg::CSR_PROC_VAR_POS, {1'b0, qp});
      csr_put(kf2_pkg::CSR_PROC_VAR_VEL, {1'b0, qv});
      csr_put(kf2_pkg::CSR_INIT_VAR, $urandom);
      csr_write <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_data <= $urandom;
      @(posedge clock);
      csr_write <= 1'b0;
      dt_reg = dt; u_pos = longint'($signed(up)); u_vel = longint'($signed(uv));
      r_reg = r; q_pos = qp; q_vel = qv;
   endtask

   function automatic logic signed [31:0] pick_position();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      endcase
   endfunction

   task automatic test_directed();
      send_word(32'sd0);
      send_word(32'sh7fffffff);
      send_word(32'sh80000000);
      send_word(32'sd65536);
      send_word(-32'sd65536);
      send_word(32'sd1);
      send_word(-32'sd1);
      send_word(32'sh55555555);
      send_word(32'shaaaaaaaa);
      // zero noise and zero step, then extreme registers
      apply_settings(31'd0, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0);
      repeat (4) send_word(pick_position());
      apply_settings(31'h7fffffff, 32'h7fffffff, 32'h80000000,
                     31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      repeat (4) send_word(pick_position());
      apply_settings(31'h7fffffff, 32'h80000000, 32'h7fffffff, 31'd0, 31'd0, 31'd0);
      repeat (4) send_word(pick_position());
   endtask

   task automatic test_random_phases(int phases, int words);
      for (int p = 0; p < phases; p++) begin
         if ($urandom_range(0, 3) == 0)
            apply_settings(31'($urandom), $urandom, $urandom, 31'($urandom),
                           31'($urandom), 31'($urandom));
         else
            apply_settings(31'($urandom_range(0, 32'h20000)),
                           $signed($urandom_range(0, 32'h2000)) - 32'sh1000,
                           $signed($urandom_range(0, 32'h200)) - 32'sh100,
                           31'($urandom_range(0, 32'h100000)),
                           31'($urandom_range(0, 32'h4000)),
                           31'($urandom_range(0, 32'h400)));
         for (int i = 0; i < words; i++) send_word(pick_position());
      end
   endtask

   task automatic test_drain_pause();
      repeat (5) send_word(pick_position());
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (5) send_word(pick_position());
   endtask

   task automatic test_back_to_back();
      steady_run = 1'b1;
      test_random_phases(2, 40);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases(10, 50);
      test_drain_pause();
      test_back_to_back();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/kf2_pkg.sv
rtl/kf2_div.sv
rtl/kf2_datapath.sv
rtl/kf2_ctrl.sv
rtl/kalman_filter_2state_1d_top.sv
tb/testbench.sv
